[hw/rtl/kct_pkg.sv]
// shared types, status codes and defaults for the keyed count table
package kct_pkg;

   localparam int KCT_ENTRIES = 16;

   localparam logic [4:0] CAP_RESET = 5'd16;

   localparam logic [0:0] CMD_ADD      = 1'b0;
   localparam logic [0:0] CMD_WITHDRAW = 1'b1;

   localparam logic [2:0] ST_MERGED    = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_WITHDRAWN = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_SHORT     = 3'd5;
   localparam logic [2:0] ST_MISSING   = 3'd6;

   typedef struct packed {
      logic        kind;
      logic [15:0] volume;
      logic [15:0] count;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // capture request, clear index
      logic rd_en;         // read table
      logic rd_next;       // read at index + 1 instead of index
      logic idx_inc;
      logic resolve_hit;   // merge, withdraw or short on the entry at index
      logic resolve_miss;  // insert, full or not found
      logic shift_wr;      // move read entry down to index
      logic shift_done;    // finish a removal
      logic publish;       // load result into output register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_end;     // index reached occupancy
      logic shift_end;  // no entry above index
      logic match;      // read entry has the request key
      logic remove;     // hit withdraw empties the entry
      logic out_free;   // output register can take a result
   } ctl_sts_type;

endpackage

[hw/rtl/kct_ctrl.sv]
// sequencer for search, update and shift-down of the keyed count table
module kct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  kct_pkg::ctl_sts_type sts,
   output kct_pkg::ctl_cmd_type cmd
);
   import kct_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRD,
      S_SCHK,
      S_HIT,
      S_MISS,
      S_SHRD,
      S_SHWR,
      S_POST
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            if (sts.at_end) begin
               state_in = S_MISS;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCHK;
            end
         end
         S_SCHK: begin
            if (sts.match) begin
               state_in = S_HIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRD;
            end
         end
         S_HIT: begin
            if (sts.remove) begin
               state_in = S_SHRD;
            end else begin
               cmd.resolve_hit = 1'b1;
               state_in        = S_POST;
            end
         end
         S_MISS: begin
            cmd.resolve_miss = 1'b1;
            state_in         = S_POST;
         end
         S_SHRD: begin
            if (sts.shift_end) begin
               cmd.shift_done = 1'b1;
               state_in       = S_POST;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHRD;
         end
         S_POST: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               ready_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            ready_in = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE)
      else $error("input ready outside idle");

   a_one_resolve: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.resolve_hit, cmd.resolve_miss, cmd.shift_done}) <= 1)
      else $error("more than one result resolved in a cycle");

   a_publish_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> ready_ff)
      else $error("input not reopened after result");

endmodule

[hw/rtl/kct_datapath.sv]
// table memory, request and result registers of the keyed count table
module kct_datapath #(
   parameter int ENTRIES = kct_pkg::KCT_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kct_pkg::ctl_cmd_type cmd,
   output kct_pkg::ctl_sts_type sts,
   input  logic                 in_command,
   input  logic                 in_kind,
   input  logic [15:0]          in_volume,
   input  logic [15:0]          in_quantity,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2:0]           out_status,
   output logic [15:0]          out_count,
   output logic [4:0]           out_used
);
   import kct_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   entry_type   table_mem [ENTRIES];
   entry_type   rd_ff;

   logic          cmd_ff;
   logic          kind_ff;
   logic [15:0]   volume_ff;
   logic [15:0]   qty_ff;
   logic [4:0]    cap_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [15:0]   res_count_ff, res_count_in;
   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [15:0]   rsp_count_ff;
   logic [4:0]    rsp_used_ff;

   logic [CW-1:0] idx_next;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_data;
   logic [16:0]   sum;
   logic [15:0]   sat;
   logic [15:0]   left;
   logic          short;
   logic          can_insert;

   always_comb begin
      idx_next   = CW'(idx_ff + 1'b1);
      sum        = {1'b0, rd_ff.count} + {1'b0, qty_ff};
      sat        = sum[16] ? 16'hFFFF : sum[15:0];
      short      = rd_ff.count < qty_ff;
      left       = rd_ff.count - qty_ff;
      // capacity above the table size counts as the table size
      can_insert = (32'(occ_ff) < 32'(cap_ff)) && (32'(occ_ff) < ENTRIES);

      sts.at_end    = idx_ff >= occ_ff;
      sts.shift_end = idx_next >= occ_ff;
      sts.match     = (rd_ff.kind == kind_ff) && (rd_ff.volume == volume_ff);
      sts.remove    = (cmd_ff == CMD_WITHDRAW) && !short && (left == 16'd0);
      sts.out_free  = !rsp_valid_ff || rsp_tready;

      rd_addr = cmd.rd_next ? idx_next[IW-1:0] : idx_ff[IW-1:0];

      wr_en   = 1'b0;
      wr_addr = idx_ff[IW-1:0];
      wr_data = rd_ff;
      if (cmd.resolve_hit) begin
         wr_en   = (cmd_ff == CMD_ADD) || !short;
         wr_data = '{kind: kind_ff, volume: volume_ff,
                     count: (cmd_ff == CMD_ADD) ? sat : left};
      end else if (cmd.resolve_miss) begin
         wr_en   = (cmd_ff == CMD_ADD) && can_insert;
         wr_addr = occ_ff[IW-1:0];
         wr_data = '{kind: kind_ff, volume: volume_ff, count: qty_ff};
      end else if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end

      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      if (cmd.resolve_hit) begin
         if (cmd_ff == CMD_ADD) begin
            res_status_in = ST_MERGED;
            res_count_in  = sat;
         end else if (short) begin
            res_status_in = ST_SHORT;
            res_count_in  = rd_ff.count;
         end else begin
            res_status_in = ST_WITHDRAWN;
            res_count_in  = left;
         end
      end else if (cmd.resolve_miss) begin
         res_count_in = 16'd0;
         if (cmd_ff == CMD_WITHDRAW) begin
            res_status_in = ST_MISSING;
         end else if (can_insert) begin
            res_status_in = ST_INSERTED;
            res_count_in  = qty_ff;
            occ_in        = CW'(occ_ff + 1'b1);
         end else begin
            res_status_in = ST_FULL;
         end
      end else if (cmd.shift_done) begin
         res_status_in = ST_REMOVED;
         res_count_in  = 16'd0;
         occ_in        = CW'(occ_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= in_command;
         kind_ff   <= in_kind;
         volume_ff <= in_volume;
         qty_ff    <= in_quantity;
      end
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_used_ff   <= 5'(occ_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_count  = rsp_count_ff;
   assign out_used   = rsp_used_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= ENTRIES)
      else $error("occupancy above table size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.resolve_miss && cmd_ff == CMD_ADD && can_insert)
      |=> occ_ff == CW'($past(occ_ff) + 1'b1))
      else $error("insert did not grow occupancy");

endmodule

[hw/rtl/keyed_count_table.sv]
// keyed count table: one result per request, search over a single-port table
// an item reads the entries in turn until its key is found or the occupancy is reached, then
// updates or inserts; on a removal each later entry is then read and written one place down
// the result may also wait on the result side; one request at a time
// the table memory takes one read or one write a cycle, with registered read
// synchronous reset empties the table and sets the capacity to 16; no clearing
module keyed_count_table #(
   parameter int ENTRIES = kct_pkg::KCT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item_volume, quantity
   input  logic [1:0]  req_tuser,   // command, item_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // count_after, entries_used, zero pad
   output logic [2:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // capacity_in_use
);
   import kct_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic [15:0] count_after;
   logic [4:0]  entries_used;

   kct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kct_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_command  (req_tuser[0]),
      .in_kind     (req_tuser[1]),
      .in_volume   (req_tdata[15:0]),
      .in_quantity (req_tdata[31:16]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_status  (rsp_tuser),
      .out_count   (count_after),
      .out_used    (entries_used)
   );

   assign rsp_tdata = {3'b000, entries_used, count_after};

endmodule

[bench/testbench.sv]
// self-checking bench for the keyed count table: directed and random stock requests
module testbench;
   import kct_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 500;
   localparam int SETTLE         = 80;
   localparam int POOL_KEYS      = 20;
   localparam int PHASE_ITEMS    = 60;
   localparam logic [4:0] PHASE_CAPS [8] =
      '{5'd0, 5'd31, 5'd2, 5'd16, 5'd1, 5'd7, 5'd17, 5'd16};

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] count;
      logic [4:0]  used;
   } outcome_type;

   // mirror of the table contents plus the queue of results still owed
   class stock_ledger_type;
      logic        kind_at   [KCT_ENTRIES];
      logic [15:0] volume_at [KCT_ENTRIES];
      logic [15:0] count_at  [KCT_ENTRIES];
      int unsigned used;
      logic [4:0]  capacity;
      outcome_type due_outcomes [$];
      int unsigned mismatches;
      int unsigned requests;
      int unsigned results;
      int unsigned status_seen [8];

      function new();
         used       = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
         requests   = 0;
         results    = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int find_slot(logic kind, logic [15:0] volume);
         for (int i = 0; i < used; i++)
            if (kind_at[i] == kind && volume_at[i] == volume) return i;
         return -1;
      endfunction

      function bit lookup(input logic kind, input logic [15:0] volume,
                          output logic [15:0] count);
         int slot;
         slot  = find_slot(kind, volume);
         count = (slot >= 0) ? count_at[slot] : 16'd0;
         return slot >= 0;
      endfunction

      function outcome_type predict_outcome(logic cmd, logic kind, logic [15:0] volume,
                                            logic [15:0] qty);
         outcome_type o;
         int          slot;
         int unsigned limit;
         int unsigned sum;
         limit   = (capacity > KCT_ENTRIES) ? KCT_ENTRIES : capacity;
         slot    = find_slot(kind, volume);
         o.count = '0;
         if (cmd == CMD_ADD) begin
            if (slot >= 0) begin
               sum = count_at[slot] + qty;
               if (sum > 32'hFFFF) sum = 32'hFFFF;
               count_at[slot] = sum[15:0];
               o.count  = sum[15:0];
               o.status = ST_MERGED;
            end else if (used < limit) begin
               kind_at[used]   = kind;
               volume_at[used] = volume;
               count_at[used]  = qty;
               used++;
               o.count  = qty;
               o.status = ST_INSERTED;
            end else begin
               o.status = ST_FULL;
            end
         end else begin
            if (slot < 0) begin
               o.status = ST_MISSING;
            end else if (count_at[slot] < qty) begin
               o.count  = count_at[slot];
               o.status = ST_SHORT;
            end else if (count_at[slot] == qty) begin
               // emptied entry leaves, later ones close the gap
               for (int j = slot; j + 1 < used; j++) begin
                  kind_at[j]   = kind_at[j + 1];
                  volume_at[j] = volume_at[j + 1];
                  count_at[j]  = count_at[j + 1];
               end
               used--;
               o.status = ST_REMOVED;
            end else begin
               count_at[slot] = count_at[slot] - qty;
               o.count  = count_at[slot];
               o.status = ST_WITHDRAWN;
            end
         end
         o.used = used[4:0];
         return o;
      endfunction

      function void note_request(logic cmd, logic kind, logic [15:0] volume,
                                 logic [15:0] qty);
         requests++;
         due_outcomes.push_back(predict_outcome(cmd, kind, volume, qty));
      endfunction

      function void check_response(logic [2:0] status, logic [15:0] count,
                                   logic [4:0] used_now);
         outcome_type want;
         results++;
         status_seen[status]++;
         if (due_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d count %0d entries %0d",
                        status, count, used_now);
            return;
         end
         want = due_outcomes.pop_front();
         if (want.status !== status || want.count !== count
             || want.used !== used_now) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result %0d mismatch: expected status %0d count %0d entries %0d,",
                         " got status %0d count %0d entries %0d"},
                        results, want.status, want.count, want.used,
                        status, count, used_now);
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // item_volume, quantity
   logic [1:0]  req_tuser   = '0;   // command, item_kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // count_after, entries_used, zero pad
   logic [2:0]  rsp_tuser;          // status
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;   // capacity_in_use

   stock_ledger_type ledger;
   bit          sender_idle_on    = 1'b1;
   bit          receiver_idle_on  = 1'b1;
   bit          long_hold_request = 1'b0;
   int unsigned quiet_cycles      = 0;
   logic        pool_kind   [POOL_KEYS];
   logic [15:0] pool_volume [POOL_KEYS];

   keyed_count_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // transfers on both channels, plus the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            ledger.check_response(rsp_tuser, rsp_tdata[15:0], rsp_tdata[20:16]);
         if (req_tvalid && req_tready)
            ledger.note_request(req_tuser[0], req_tuser[1], req_tdata[15:0],
                                req_tdata[31:16]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      int unsigned span;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold_request) begin
            rsp_tready        <= 1'b0;
            long_hold_request = 1'b0;
            span              = LONG_HOLD;
         end else if (receiver_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            span       = $urandom_range(1, 9);
         end else begin
            rsp_tready <= 1'b1;
            span       = $urandom_range(1, 12);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic send_item(logic cmd, logic kind, logic [15:0] volume, logic [15:0] qty);
      req_tvalid <= 1'b1;
      req_tuser  <= {kind, cmd};
      req_tdata  <= {qty, volume};
      do @(posedge clock); while (!req_tready);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // stop offering and let every owed result come back
   task automatic drain_table;
      req_tvalid <= 1'b0;
      while (ledger.due_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.capacity = value;
   endtask

   task automatic random_item;
      int          p;
      int unsigned r;
      logic        kind;
      logic        cmd;
      logic [15:0] volume;
      logic [15:0] qty;
      logic [15:0] have;
      bit          found;
      if ($urandom_range(0, 99) < 85) begin
         p      = $urandom_range(0, POOL_KEYS - 1);
         kind   = pool_kind[p];
         volume = pool_volume[p];
      end else begin
         kind   = 1'($urandom_range(0, 1));
         volume = 16'($urandom_range(0, 65535));
      end
      cmd = 1'($urandom_range(0, 1));
      r   = $urandom_range(0, 99);
      if (cmd == CMD_ADD) begin
         if (r < 10)      qty = '0;
         else if (r < 60) qty = 16'($urandom_range(1, 20));
         else if (r < 70) qty = 16'hFFFF;
         else             qty = 16'($urandom_range(0, 65535));
      end else begin
         found = ledger.lookup(kind, volume, have);
         // mostly exact or partial withdrawals so entries drain and shift
         if (!found || r >= 85)
            qty = (r < 50) ? 16'($urandom_range(1, 20)) : 16'($urandom_range(0, 65535));
         else if (r < 40)
            qty = have;
         else if (r < 70)
            qty = (have == 0) ? 16'd0 : 16'($urandom_range(1, have));
         else
            qty = (have == 16'hFFFF) ? have : have + 16'd1;
      end
      send_item(cmd, kind, volume, qty);
   endtask

   initial begin
      ledger = new();
      for (int i = 0; i < POOL_KEYS; i++) begin
         pool_kind[i]   = 1'($urandom_range(0, 1));
         pool_volume[i] = 16'($urandom_range(0, 65535));
      end
      pool_kind[0] = 1'b0;  pool_volume[0] = 16'h0000;
      pool_kind[1] = 1'b1;  pool_volume[1] = 16'hFFFF;
      pool_kind[2] = 1'b0;  pool_volume[2] = 16'hFFFF;
      pool_kind[3] = 1'b1;  pool_volume[3] = 16'h0000;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners on the reset capacity
      send_item(CMD_WITHDRAW, 1'b0, 16'h0000, 16'd0);       // empty table, key missing
      send_item(CMD_ADD,      1'b0, 16'h0000, 16'd0);       // zero-count insert
      send_item(CMD_WITHDRAW, 1'b0, 16'h0000, 16'd0);       // zero withdraw removes it
      send_item(CMD_ADD,      1'b1, 16'hFFFF, 16'hFFFF);
      send_item(CMD_ADD,      1'b1, 16'hFFFF, 16'd1);       // saturates
      send_item(CMD_ADD,      1'b0, 16'hFFFF, 16'd100);     // same volume, other kind
      send_item(CMD_WITHDRAW, 1'b1, 16'hFFFF, 16'd0);       // zero withdraw, nonzero entry
      send_item(CMD_WITHDRAW, 1'b0, 16'hFFFF, 16'd101);     // not enough stock
      send_item(CMD_ADD,      1'b1, 16'h0000, 16'd5);
      send_item(CMD_WITHDRAW, 1'b1, 16'hFFFF, 16'hFFFF);    // head removed, rest shift down
      send_item(CMD_WITHDRAW, 1'b0, 16'hFFFF, 16'd40);
      send_item(CMD_ADD,      1'b0, 16'hFFFF, 16'd0);       // zero merge
      drain_table();

      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(PHASE_CAPS[ph]);
         if (ph == 7) begin
            sender_idle_on   = 1'b0;
            receiver_idle_on = 1'b0;
         end
         if (ph == 3) long_hold_request = 1'b1;
         repeat (PHASE_ITEMS) random_item();
         drain_table();
      end

      $display("run covered %0d requests and %0d results over 8 capacity settings",
               ledger.requests, ledger.results);
      $display({"status mix: merged %0d inserted %0d full %0d withdrawn %0d",
                " removed %0d short %0d missing %0d"},
               ledger.status_seen[ST_MERGED], ledger.status_seen[ST_INSERTED],
               ledger.status_seen[ST_FULL], ledger.status_seen[ST_WITHDRAWN],
               ledger.status_seen[ST_REMOVED], ledger.status_seen[ST_SHORT],
               ledger.status_seen[ST_MISSING]);
      if (ledger.mismatches == 0 && ledger.due_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  ledger.mismatches, ledger.due_outcomes.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/kct_pkg.sv
hw/rtl/kct_ctrl.sv
hw/rtl/kct_datapath.sv
hw/rtl/keyed_count_table.sv
bench/testbench.sv
